// File: rtl/dbe_pkg.sv
package dbe_pkg;

	// item kinds, carried on tuser
	localparam logic [1:0] KIND_HDR  = 2'd0;
	localparam logic [1:0] KIND_PTR  = 2'd1;
	localparam logic [1:0] KIND_UINT = 2'd2;
	localparam logic [1:0] KIND_INT  = 2'd3;

	// header size tiers
	localparam logic [24:0] SIZE_T1      = 25'd29;
	localparam logic [24:0] SIZE_T2      = 25'd285;
	localparam logic [24:0] SIZE_T3      = 25'd65821;
	localparam logic [24:0] SIZE_MAX_ENC = 25'd16843036;

	// size codes in the first header byte
	localparam logic [7:0] CODE_EXT1 = 8'd29;
	localparam logic [7:0] CODE_EXT2 = 8'd30;
	localparam logic [7:0] CODE_EXT3 = 8'd31;

	// types at and above this one take an extended-type byte
	localparam logic [7:0] TYPE_EXT_BASE = 8'd8;
	localparam logic [7:0] TYPE_EXT_BIAS = 8'd7;
	localparam logic [7:0] TYPE_INT32    = 8'd8;
	localparam logic [24:0] INT32_BYTES  = 25'd4;

	// pointer tiers
	localparam logic [31:0] PTR_T1 = 32'd2048;
	localparam logic [31:0] PTR_T2 = 32'd526336;
	localparam logic [31:0] PTR_T3 = 32'd134744064;
	localparam logic [7:0] PTR_CODE1 = 8'h20;
	localparam logic [7:0] PTR_CODE2 = 8'h28;
	localparam logic [7:0] PTR_CODE3 = 8'h30;
	localparam logic [7:0] PTR_CODE4 = 8'h38;

	localparam int HDR_BYTES = 5;

	// one classified item: header bytes first, then payload msb first
	typedef struct packed {
		logic [HDR_BYTES-1:0][7:0] hdr;
		logic [2:0]                hcnt;
		logic [63:0]               pay;
		logic [3:0]                pcnt;
	} desc_t;

endpackage

// File: rtl/dbe_front.sv
module dbe_front (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [135:0]       s_tdata,   // type_code[7:0], size[32:8], offset[64:33], value[128:65]
	input  logic [1:0]         s_tuser,   // kind[1:0]
	output logic               wr_valid,
	input  logic               wr_ready,
	output dbe_pkg::desc_t     wr_desc
);

	logic [7:0]  type_code;
	logic [24:0] size;
	logic [31:0] offset;
	logic [63:0] value;
	logic [3:0]  len;
	logic [31:0] pr1, pr2;

	assign type_code = s_tdata[7:0];
	assign size      = s_tdata[32:8];
	assign offset    = s_tdata[64:33];
	assign value     = s_tdata[128:65];

	assign s_tready = wr_ready;
	assign wr_valid = s_tvalid;

	function automatic dbe_pkg::desc_t hdr_build(input logic [7:0] typ, input logic [24:0] sz);
		dbe_pkg::desc_t d;
		logic [24:0] sat;
		logic [7:0]  ctrl;
		logic [24:0] r1, r2, r3;
		logic [2:0]  n;
		d = '0;
		sat  = (sz > dbe_pkg::SIZE_MAX_ENC) ? dbe_pkg::SIZE_MAX_ENC : sz;
		ctrl = (typ < dbe_pkg::TYPE_EXT_BASE) ? {typ[2:0], 5'd0} : 8'd0;
		r1 = sat - dbe_pkg::SIZE_T1;
		r2 = sat - dbe_pkg::SIZE_T2;
		r3 = sat - dbe_pkg::SIZE_T3;
		if (sat < dbe_pkg::SIZE_T1) begin
			d.hdr[0] = ctrl | sat[7:0];
			n = 3'd1;
		end else if (sat < dbe_pkg::SIZE_T2) begin
			d.hdr[0] = ctrl | dbe_pkg::CODE_EXT1;
			d.hdr[1] = r1[7:0];
			n = 3'd2;
		end else if (sat < dbe_pkg::SIZE_T3) begin
			d.hdr[0] = ctrl | dbe_pkg::CODE_EXT2;
			d.hdr[1] = r2[15:8];
			d.hdr[2] = r2[7:0];
			n = 3'd3;
		end else begin
			d.hdr[0] = ctrl | dbe_pkg::CODE_EXT3;
			d.hdr[1] = r3[23:16];
			d.hdr[2] = r3[15:8];
			d.hdr[3] = r3[7:0];
			n = 3'd4;
		end
		if (typ >= dbe_pkg::TYPE_EXT_BASE) begin
			d.hdr[n] = typ - dbe_pkg::TYPE_EXT_BIAS;
			n = n + 3'd1;
		end
		d.hcnt = n;
		return d;
	endfunction

	// minimal big-endian length: one plus the index of the top nonzero byte
	always_comb begin
		len = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (value[8*i +: 8] != 8'd0) len = 4'(i + 1);
		end
	end

	assign pr1 = offset - dbe_pkg::PTR_T1;
	assign pr2 = offset - dbe_pkg::PTR_T2;

	always_comb begin
		wr_desc = '0;
		unique case (s_tuser)
			dbe_pkg::KIND_HDR: begin
				wr_desc = hdr_build(type_code, size);
			end
			dbe_pkg::KIND_PTR: begin
				if (offset < dbe_pkg::PTR_T1) begin
					wr_desc.hdr[0] = dbe_pkg::PTR_CODE1 | {5'd0, offset[10:8]};
					wr_desc.hdr[1] = offset[7:0];
					wr_desc.hcnt   = 3'd2;
				end else if (offset < dbe_pkg::PTR_T2) begin
					wr_desc.hdr[0] = dbe_pkg::PTR_CODE2 | {5'd0, pr1[18:16]};
					wr_desc.hdr[1] = pr1[15:8];
					wr_desc.hdr[2] = pr1[7:0];
					wr_desc.hcnt   = 3'd3;
				end else if (offset < dbe_pkg::PTR_T3) begin
					wr_desc.hdr[0] = dbe_pkg::PTR_CODE3 | {5'd0, pr2[26:24]};
					wr_desc.hdr[1] = pr2[23:16];
					wr_desc.hdr[2] = pr2[15:8];
					wr_desc.hdr[3] = pr2[7:0];
					wr_desc.hcnt   = 3'd4;
				end else begin
					wr_desc.hdr[0] = dbe_pkg::PTR_CODE4;
					wr_desc.hdr[1] = offset[31:24];
					wr_desc.hdr[2] = offset[23:16];
					wr_desc.hdr[3] = offset[15:8];
					wr_desc.hdr[4] = offset[7:0];
					wr_desc.hcnt   = 3'd5;
				end
			end
			dbe_pkg::KIND_UINT: begin
				wr_desc      = hdr_build(type_code, 25'(len));
				// left-align the payload so the back end shifts out msb first
				wr_desc.pay  = value << {3'(4'd8 - len), 3'b000};
				wr_desc.pcnt = len;
			end
			dbe_pkg::KIND_INT: begin
				wr_desc      = hdr_build(dbe_pkg::TYPE_INT32, dbe_pkg::INT32_BYTES);
				wr_desc.pay  = {value[31:0], 32'd0};
				wr_desc.pcnt = 4'd4;
			end
			default: wr_desc = '0;
		endcase
	end

endmodule

// File: rtl/dbe_queue.sv
module dbe_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  dbe_pkg::desc_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output dbe_pkg::desc_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dbe_pkg::desc_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers apart while empty");

endmodule

// File: rtl/dbe_back.sv
module dbe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_valid,
	output logic           rd_ready,
	input  dbe_pkg::desc_t rd_data,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,   // out_byte[7:0]
	output logic           m_tlast    // last
);

	logic [dbe_pkg::HDR_BYTES-1:0][7:0] hdr_q;
	logic [2:0]  hcnt_q;
	logic [63:0] pay_q;
	logic [3:0]  pcnt_q;
	logic        busy_q;
	logic        valid_q, last_q;
	logic [7:0]  byte_q;
	logic        emit, final_byte, load;

	assign emit       = busy_q && (!valid_q || m_tready);
	assign final_byte = ({1'b0, hcnt_q} + pcnt_q) == 4'd1;
	// take the next item on the cycle the current one sends its final byte
	assign load       = rd_valid && (!busy_q || (emit && final_byte));
	assign rd_ready   = !busy_q || (emit && final_byte);

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			hdr_q <= rd_data.hdr;
			pay_q <= rd_data.pay;
		end else if (emit) begin
			if (hcnt_q != 3'd0) begin
				for (int i = 0; i < dbe_pkg::HDR_BYTES - 1; i++) hdr_q[i] <= hdr_q[i+1];
			end else begin
				pay_q <= {pay_q[55:0], 8'd0};
			end
		end
		if (emit) begin
			byte_q <= (hcnt_q != 3'd0) ? hdr_q[0] : pay_q[63:56];
			last_q <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			hcnt_q  <= '0;
			pcnt_q  <= '0;
		end else begin
			if (emit)                valid_q <= 1'b1;
			else if (m_tready)       valid_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				hcnt_q <= rd_data.hcnt;
				pcnt_q <= rd_data.pcnt;
			end else if (emit) begin
				if (final_byte)            busy_q <= 1'b0;
				if (hcnt_q != 3'd0)        hcnt_q <= hcnt_q - 3'd1;
				else                       pcnt_q <= pcnt_q - 4'd1;
			end
		end
	end

	a_busy_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (({1'b0, hcnt_q} + pcnt_q) != 4'd0))
		else $error("serializer busy with nothing left");

	a_counts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (hcnt_q <= 3'(dbe_pkg::HDR_BYTES) && pcnt_q <= 4'd8))
		else $error("serializer byte counts out of range");

endmodule

// File: rtl/db_data_field_byte_encoder_top.sv
// channel  dir  handshake            payload
// s        in   s_tvalid / s_tready  s_tdata: type_code, size, offset, value; s_tuser: kind
// m        out  m_tvalid / m_tready  m_tdata: out_byte; m_tlast: last
//
// one output beat per cycle unless the output stalls; an item gives 1 to 10 beats
// (header plus payload), set by the back-end serializer which shifts out one byte a cycle
// on an idle block an item passes the queue, the serializer and the output register;
// items follow each other with no gap, the next one loads as the last byte leaves
// the front takes items whenever the queue has room, so input and output stall apart
// reset clears queue pointers, serializer counts and the output valid; no data is kept
module db_data_field_byte_encoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // type_code[7:0], size[32:8], offset[64:33], value[128:65]
	input  logic [1:0]   s_tuser,   // kind[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // out_byte[7:0]
	output logic         m_tlast    // last
);

	// classified items between front and back
	dbe_pkg::desc_t wr_desc, rd_desc;
	logic           wr_valid, wr_ready;
	logic           rd_valid, rd_ready;

	// front: decodes the kind and works out header and payload bytes
	dbe_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_desc  (wr_desc)
	);

	// short queue so that a stalled output does not hold the input
	dbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_desc),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_data  (rd_desc)
	);

	// back: serializes bytes into the output register, marks the final one
	dbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_data  (rd_desc),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: verif/tb_db_data_field_byte_encoder_top.sv
`timescale 1ns / 1ps

module tb_db_data_field_byte_encoder_top;

	// one input item as the sender sees it, plus a flag that holds it back
	// until every byte of earlier items has come out
	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  type_code;
		logic [24:0] size;
		logic [31:0] offset;
		logic [63:0] value;
		bit          hold;
	} field_item_t;

	// one output beat: encoded byte and end-of-item flag
	typedef struct {
		logic [7:0] data;
		logic       last;
	} enc_beat_t;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata  = '0;
	logic [1:0]   s_tuser  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;
	logic         m_tlast;

	field_item_t pending_items[$];   // items not yet offered to the block
	enc_beat_t   exp_beats[$];       // encoded bytes still owed by the block
	logic [7:0]  enc_bytes[$];       // scratch for the item being encoded

	field_item_t cur_item;
	int          gap_left   = 0;
	int          sent_count = 0;
	int          stall_left = 0;
	int          beat_count = 0;
	int          err_count  = 0;

	db_data_field_byte_encoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// byte encoder predictor
	// ------------------------------------------------------------------

	// append one byte to the item being encoded
	function automatic void add_byte(input logic [7:0] b);
		enc_bytes = {enc_bytes, b};
	endfunction

	// control header: type in the top three bits for small types, size code
	// below, extension bytes for large sizes, extended-type byte last
	function automatic void put_header(input logic [7:0] tcode, input logic [24:0] sz);
		logic [7:0]  ctl;
		logic [24:0] s;
		logic [24:0] r;
		ctl = (tcode < dbe_pkg::TYPE_EXT_BASE) ? {tcode[2:0], 5'd0} : 8'd0;
		// oversized sizes clamp
		s   = (sz > dbe_pkg::SIZE_MAX_ENC) ? dbe_pkg::SIZE_MAX_ENC : sz;
		if (s < dbe_pkg::SIZE_T1) begin
			add_byte(ctl | s[7:0]);
		end else if (s < dbe_pkg::SIZE_T2) begin
			r = s - dbe_pkg::SIZE_T1;
			add_byte(ctl | dbe_pkg::CODE_EXT1);
			add_byte(r[7:0]);
		end else if (s < dbe_pkg::SIZE_T3) begin
			r = s - dbe_pkg::SIZE_T2;
			add_byte(ctl | dbe_pkg::CODE_EXT2);
			add_byte(r[15:8]);
			add_byte(r[7:0]);
		end else begin
			r = s - dbe_pkg::SIZE_T3;
			add_byte(ctl | dbe_pkg::CODE_EXT3);
			add_byte(r[23:16]);
			add_byte(r[15:8]);
			add_byte(r[7:0]);
		end
		if (tcode >= dbe_pkg::TYPE_EXT_BASE)
			add_byte(tcode - dbe_pkg::TYPE_EXT_BIAS);
	endfunction

	// pointer: four tiers, the middle two biased by the reach of the tiers below, the top one raw
	function automatic void put_pointer(input logic [31:0] off);
		logic [31:0] r;
		if (off < dbe_pkg::PTR_T1) begin
			add_byte(dbe_pkg::PTR_CODE1 | {5'd0, off[10:8]});
			add_byte(off[7:0]);
		end else if (off < dbe_pkg::PTR_T2) begin
			r = off - dbe_pkg::PTR_T1;
			add_byte(dbe_pkg::PTR_CODE2 | {5'd0, r[18:16]});
			add_byte(r[15:8]);
			add_byte(r[7:0]);
		end else if (off < dbe_pkg::PTR_T3) begin
			r = off - dbe_pkg::PTR_T2;
			add_byte(dbe_pkg::PTR_CODE3 | {5'd0, r[26:24]});
			add_byte(r[23:16]);
			add_byte(r[15:8]);
			add_byte(r[7:0]);
		end else begin
			add_byte(dbe_pkg::PTR_CODE4);
			add_byte(off[31:24]);
			add_byte(off[23:16]);
			add_byte(off[15:8]);
			add_byte(off[7:0]);
		end
	endfunction

	// works out every byte of one accepted item and queues it as owed
	function automatic void encode_item(input field_item_t it);
		int        len;
		enc_beat_t b;
		enc_bytes.delete();
		case (it.kind)
			dbe_pkg::KIND_HDR: put_header(it.type_code, it.size);
			dbe_pkg::KIND_PTR: put_pointer(it.offset);
			dbe_pkg::KIND_UINT: begin
				// minimal big-endian length, zero takes no payload
				len = 0;
				for (int i = 0; i < 8; i++)
					if ((it.value >> (8 * i)) != 64'd0)
						len = i + 1;
				put_header(it.type_code, 25'(len));
				for (int i = len - 1; i >= 0; i--)
					add_byte(it.value[8*i +: 8]);
			end
			default: begin
				// signed kind ignores type_code, always four bytes
				put_header(dbe_pkg::TYPE_INT32, dbe_pkg::INT32_BYTES);
				add_byte(it.value[31:24]);
				add_byte(it.value[23:16]);
				add_byte(it.value[15:8]);
				add_byte(it.value[7:0]);
			end
		endcase
		foreach (enc_bytes[i]) begin
			b.data    = enc_bytes[i];
			b.last    = (i == enc_bytes.size() - 1);
			exp_beats = {exp_beats, b};
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// idle length: mostly none or short, now and then long;
	// steady stretches have no idling at all
	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// fully random item, unused fields carry junk the block must ignore
	function automatic field_item_t rand_item();
		field_item_t it;
		int          n;
		it.kind      = 2'($urandom_range(0, 3));
		it.type_code = 8'($urandom);
		it.size      = 25'($urandom);
		it.offset    = $urandom;
		it.value     = {$urandom, $urandom};
		it.hold      = 1'b0;
		case (it.kind)
			dbe_pkg::KIND_HDR: begin
				// small types get their own share, the rest are random and mostly take an extra byte
				if ($urandom_range(0, 1) == 0)
					it.type_code = 8'($urandom_range(0, 7));
				case ($urandom_range(0, 5))
					0: it.size = 25'($urandom_range(0, 28));
					1: it.size = 25'($urandom_range(29, 284));
					2: it.size = 25'($urandom_range(285, 65820));
					3: it.size = 25'($urandom_range(65821, 16843036));
					4: it.size = 25'($urandom_range(16843037, 33554431));
					default: begin
						// straddle a tier edge
						case ($urandom_range(0, 3))
							0: it.size = dbe_pkg::SIZE_T1;
							1: it.size = dbe_pkg::SIZE_T2;
							2: it.size = dbe_pkg::SIZE_T3;
							default: it.size = dbe_pkg::SIZE_MAX_ENC;
						endcase
						it.size = it.size + 25'($urandom_range(0, 2)) - 25'd1;
					end
				endcase
			end
			dbe_pkg::KIND_PTR: begin
				case ($urandom_range(0, 4))
					0: it.offset = $urandom_range(0, 2047);
					1: it.offset = $urandom_range(2048, 526335);
					2: it.offset = $urandom_range(526336, 134744063);
					3: it.offset = $urandom_range(134744064, 32'hFFFF_FFFF);
					default: begin
						case ($urandom_range(0, 2))
							0: it.offset = dbe_pkg::PTR_T1;
							1: it.offset = dbe_pkg::PTR_T2;
							default: it.offset = dbe_pkg::PTR_T3;
						endcase
						it.offset = it.offset + $urandom_range(0, 2) - 32'd1;
					end
				endcase
			end
			dbe_pkg::KIND_UINT: begin
				// spread over every payload length, zero included
				n = $urandom_range(0, 8);
				if (n == 0)
					it.value = 64'd0;
				else if (n < 8)
					it.value = it.value & ((64'd1 << (8 * n)) - 64'd1);
				if ($urandom_range(0, 1) == 0)
					it.type_code = 8'($urandom_range(0, 7));
			end
			default: ;
		endcase
		return it;
	endfunction

	// directed item: only the fields the kind uses are forced
	task automatic add_item(input logic [1:0] kind, input logic [7:0] tcode,
			input logic [24:0] sz, input logic [31:0] off, input logic [63:0] val);
		field_item_t it;
		it      = rand_item();
		it.kind = kind;
		case (kind)
			dbe_pkg::KIND_HDR: begin
				it.type_code = tcode;
				it.size      = sz;
			end
			dbe_pkg::KIND_PTR:  it.offset = off;
			dbe_pkg::KIND_UINT: begin
				it.type_code = tcode;
				it.value     = val;
			end
			default:   it.value = val;
		endcase
		pending_items = {pending_items, it};
	endtask

	// ------------------------------------------------------------------
	// input driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			// beat taken: predict its bytes and pick the idle time after it
			if (s_tvalid && s_tready) begin
				encode_item(cur_item);
				sent_count++;
				gap_left = pick_gap((sent_count % 50) < 12);
			end
			// slot free: offer the next item, or idle with junk on the bus
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
					s_tdata  <= 136'({$urandom, $urandom, $urandom, $urandom, $urandom});
					s_tuser  <= 2'($urandom);
				end else if (pending_items.size() > 0 &&
						!(pending_items[0].hold && exp_beats.size() != 0)) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {7'd0, cur_item.value, cur_item.offset,
						cur_item.size, cur_item.type_code};
					s_tuser  <= cur_item.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// output monitor and checker
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		enc_beat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				beat_count++;
				if (exp_beats.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected beat data %02h last %0b",
							$realtime, m_tdata, m_tlast);
				end else begin
					want = exp_beats.pop_front();
					if (m_tdata !== want.data || m_tlast !== want.last) begin
						err_count++;
						if (err_count <= 10)
							$display("%0t: beat %0d expected %02h last %0b, got %02h last %0b",
								$realtime, beat_count, want.data, want.last,
								m_tdata, m_tlast);
					end
				end
			end
			// back-pressure: random stalls, with stall-free stretches
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall_left = pick_gap((beat_count % 200) < 40);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		field_item_t it;

		// header size tiers, their edges, clamping and the extended-type byte
		add_item(dbe_pkg::KIND_HDR, 8'd0,   25'd0,        '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd7,   25'd28,       '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd1,   25'd29,       '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd2,   25'd284,      '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd3,   25'd285,      '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd5,   25'd65820,    '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd6,   25'd65821,    '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd4,   25'd16843036, '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd9,   25'd16843037, '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd255, 25'h1FF_FFFF, '0, '0);
		add_item(dbe_pkg::KIND_HDR, 8'd8,   25'd0,        '0, '0);
		// pointer tiers and their edges
		add_item(dbe_pkg::KIND_PTR, '0, '0, 32'd0,          '0);
		add_item(dbe_pkg::KIND_PTR, '0, '0, 32'd2047,       '0);
		add_item(dbe_pkg::KIND_PTR, '0, '0, 32'd2048,       '0);
		add_item(dbe_pkg::KIND_PTR, '0, '0, 32'd526335,     '0);
		add_item(dbe_pkg::KIND_PTR, '0, '0, 32'd526336,     '0);
		add_item(dbe_pkg::KIND_PTR, '0, '0, 32'd134744063,  '0);
		add_item(dbe_pkg::KIND_PTR, '0, '0, 32'd134744064,  '0);
		add_item(dbe_pkg::KIND_PTR, '0, '0, 32'hFFFF_FFFF,  '0);
		// unsigned: zero value, one byte, longest item, eight-bit type
		add_item(dbe_pkg::KIND_UINT, 8'd2,   '0, '0, 64'd0);
		add_item(dbe_pkg::KIND_UINT, 8'd3,   '0, '0, 64'd1);
		add_item(dbe_pkg::KIND_UINT, 8'd200, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(dbe_pkg::KIND_UINT, 8'd8,   '0, '0, 64'h0000_0001_0000_0000);
		// signed: sign bit alone with junk above bit 31, and all ones
		add_item(dbe_pkg::KIND_INT, '0, '0, '0, 64'hA5A5_A5A5_8000_0000);
		add_item(dbe_pkg::KIND_INT, '0, '0, '0, 64'h0000_0000_FFFF_FFFF);

		// random part; every 60th item waits for the block to drain first
		for (int i = 0; i < 205; i++) begin
			it            = rand_item();
			it.hold       = (i % 60 == 0);
			pending_items = {pending_items, it};
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// all items accepted, then every owed byte out, then a quiet tail
		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (exp_beats.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
